// ===== hdl/dpic_pkg.sv =====
// Shared widths, sqrt stage data and sequencer states for the diagonal pair index converter.
package dpic_pkg;

  localparam int COORD_BITS = 16;
  // row/col result width and root width
  localparam int RW    = COORD_BITS + 1;
  localparam int VW    = 2 * COORD_BITS + 1;
  // radicand is 2*value
  localparam int RAD_W = 2 * RW;
  localparam int REM_W = RW + 2;
  // diagonal index, one bit over the root
  localparam int DW    = RW + 1;
  localparam int PW    = 2 * DW;
  localparam int TW    = PW - 1;

  typedef struct packed {
    logic [RAD_W-1:0] rad;
    logic [REM_W-1:0] rem;
    logic [RW-1:0]    root;
  } sq_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROOT,
    ST_MUL,
    ST_ADJ,
    ST_FIN
  } state_t;

endpackage

// ===== hdl/dpic_sqrt_cell.sv =====
// One digit step of the square root chain: two radicand bits in, one root bit out.
module dpic_sqrt_cell
  import dpic_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic src_v,
  input  sq_t  src_d,
  output logic dst_v,
  output sq_t  dst_d
);

  logic             v_r;
  sq_t              d_r;
  sq_t              d_nxt;
  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             fits;

  always_comb begin
    rem_sh = {src_d.rem[REM_W-3:0], src_d.rad[RAD_W-1 -: 2]};
    trial  = {src_d.root, 2'b01};
    fits   = (rem_sh >= trial);
    d_nxt.rad  = {src_d.rad[RAD_W-3:0], 2'b00};
    d_nxt.rem  = fits ? (rem_sh - trial) : rem_sh;
    d_nxt.root = {src_d.root[RW-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= src_v;
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end

  assign dst_v = v_r;
  assign dst_d = d_r;

endmodule

// ===== hdl/diagonal_pair_index_converter.sv =====
// Diagonal pair index converter: Cantor pairing (command 0) and its inverse (command 1).
// Command 0 steps through the MUL, ADJ and FIN states; command 1 first waits in ROOT for
// the RW-cell square root chain, which resolves one root bit per cell, and then does the same.
// One request is in flight at a time: busy drops in the result cycle, so a new request
// is taken only after the last one has produced its result.
// out_valid pulses for one cycle; the receiver cannot stall it.
// Synchronous active-low reset returns the sequencer to idle and clears out_valid.
module diagonal_pair_index_converter
  import dpic_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_command,
  input  logic [COORD_BITS-1:0] in_row_in,
  input  logic [COORD_BITS-1:0] in_col_in,
  input  logic [VW-1:0]         in_value_in,
  output logic                  out_valid,
  output logic [VW-1:0]         out_value_out,
  output logic [RW-1:0]         out_row_out,
  output logic [RW-1:0]         out_col_out,
  output logic                  out_input_error
);

  state_t                state_r, state_nxt;
  logic                  cmd_r, cmd_nxt;
  logic [COORD_BITS-1:0] row_r, row_nxt;
  logic [COORD_BITS-1:0] col_r, col_nxt;
  logic [VW-1:0]         val_r, val_nxt;
  logic                  err_r, err_nxt;
  logic [RW-1:0]         s_r, s_nxt;
  logic [TW-1:0]         tri_r, tri_nxt;
  logic [TW-1:0]         base_r, base_nxt;
  logic [DW-1:0]         dg_r, dg_nxt;
  logic                  ov_r, ov_nxt;
  logic [VW-1:0]         ovalue_r, ovalue_nxt;
  logic [RW-1:0]         orow_r, orow_nxt;
  logic [RW-1:0]         ocol_r, ocol_nxt;
  logic                  oerr_r, oerr_nxt;

  logic                  chain_v [RW+1];
  sq_t                   chain_d [RW+1];

  logic [DW-1:0]         dsum;
  logic [DW-1:0]         mul_a;
  logic [DW-1:0]         mul_b;
  logic [PW-1:0]         prod;
  logic [TW-1:0]         val_ext;
  logic [TW-1:0]         s_ext;
  logic [TW-1:0]         diff;
  logic [DW-1:0]         c_fin;
  logic [DW:0]           r_fin;
  logic                  too_big;
  logic [TW-1:0]         vsum;

  assign busy = (state_r != ST_IDLE);

  // feed the root chain with 2*value
  assign chain_v[0]      = start && (state_r == ST_IDLE) && in_command;
  assign chain_d[0].rad  = {in_value_in, 1'b0};
  assign chain_d[0].rem  = '0;
  assign chain_d[0].root = '0;

  for (genvar i = 0; i < RW; i++) begin : g_cell
    dpic_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .src_v (chain_v[i]),
      .src_d (chain_d[i]),
      .dst_v (chain_v[i+1]),
      .dst_d (chain_d[i+1])
    );
  end

  // tri(d-1) = (d-1)*d/2 for command 0, tri(s) = s*(s+1)/2 for command 1
  assign dsum    = DW'(row_r) + DW'(col_r) - DW'(1);
  assign mul_a   = cmd_r ? DW'(s_r) : (dsum - DW'(1));
  assign mul_b   = cmd_r ? (DW'(s_r) + DW'(1)) : dsum;
  assign prod    = PW'(mul_a) * PW'(mul_b);
  assign val_ext = TW'(val_r);
  assign s_ext   = TW'(s_r);

  assign diff    = val_ext - base_r;
  assign c_fin   = diff[DW-1:0];
  assign r_fin   = (DW+1)'(dg_r) + (DW+1)'(1) - (DW+1)'(c_fin);
  assign too_big = (|r_fin[DW:RW]) || (|c_fin[DW-1:RW]);
  assign vsum    = tri_r + TW'(col_r);

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    val_nxt    = val_r;
    err_nxt    = err_r;
    s_nxt      = s_r;
    tri_nxt    = tri_r;
    base_nxt   = base_r;
    dg_nxt     = dg_r;
    ov_nxt     = 1'b0;
    ovalue_nxt = ovalue_r;
    orow_nxt   = orow_r;
    ocol_nxt   = ocol_r;
    oerr_nxt   = oerr_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd_nxt = in_command;
          row_nxt = in_row_in;
          col_nxt = in_col_in;
          val_nxt = in_value_in;
          if (in_command) begin
            err_nxt   = (in_value_in == '0);
            state_nxt = ST_ROOT;
          end else begin
            err_nxt   = (in_row_in == '0) || (in_col_in == '0);
            state_nxt = ST_MUL;
          end
        end
      end
      ST_ROOT: begin
        if (chain_v[RW]) begin
          s_nxt     = chain_d[RW].root;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        tri_nxt   = prod[PW-1:1];
        state_nxt = ST_ADJ;
      end
      ST_ADJ: begin
        // pick the smallest diagonal whose triangle covers the value
        if (tri_r >= val_ext) begin
          base_nxt = tri_r - s_ext;
          dg_nxt   = DW'(s_r);
        end else begin
          base_nxt = tri_r;
          dg_nxt   = DW'(s_r) + DW'(1);
        end
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        ov_nxt     = 1'b1;
        ovalue_nxt = '0;
        orow_nxt   = '0;
        ocol_nxt   = '0;
        oerr_nxt   = err_r;
        if (!err_r) begin
          if (cmd_r) begin
            if (too_big) begin
              oerr_nxt = 1'b1;
            end else begin
              orow_nxt = r_fin[RW-1:0];
              ocol_nxt = c_fin[RW-1:0];
            end
          end else begin
            ovalue_nxt = vsum[VW-1:0];
          end
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    row_r    <= row_nxt;
    col_r    <= col_nxt;
    val_r    <= val_nxt;
    err_r    <= err_nxt;
    s_r      <= s_nxt;
    tri_r    <= tri_nxt;
    base_r   <= base_nxt;
    dg_r     <= dg_nxt;
    ovalue_r <= ovalue_nxt;
    orow_r   <= orow_nxt;
    ocol_r   <= ocol_nxt;
    oerr_r   <= oerr_nxt;
  end

  assign out_valid       = ov_r;
  assign out_value_out   = ovalue_r;
  assign out_row_out     = orow_r;
  assign out_col_out     = ocol_r;
  assign out_input_error = oerr_r;

endmodule
